// ----- sv/rc4_pkg.sv -----
// ============================================================================
// rc4_pkg
// Shared types and constants for the RC4 stream cipher block.
// ============================================================================
`default_nettype none

package rc4_pkg;

    // Key store geometry
    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KEY_LEN_W = 9;

    // S-box geometry
    localparam int SBOX_DEPTH = 256;
    localparam int BYTE_W     = 8;

    // Command queue between front and engine
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Command codes handed from the front to the engine
    typedef enum logic [1:0] {
        OP_KEY_WR,
        OP_DATA,
        OP_DATA_START
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic [7:0]        key_index;
    } cmd_t;

    // Engine sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_RD,
        ST_KS_ACC,
        ST_KS_WR_N,
        ST_KS_WR_A,
        ST_PG_RD_I,
        ST_PG_RD_J,
        ST_PG_SWAP,
        ST_PG_OUT
    } eng_state_t;

endpackage

`default_nettype wire

// ----- sv/rc4_front.sv -----
// ============================================================================
// rc4_front
// Accepts input items, classifies them into engine commands and holds the
// key length register.
// ============================================================================
`default_nettype none

module rc4_front
    import rc4_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input item channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_req_type,
    input  wire logic [7:0]           s_byte_value,
    input  wire logic [7:0]           s_key_index,
    input  wire logic                 s_start_message,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [KEY_LEN_W-1:0] cfg_data,
    // command out to queue
    output logic                      cmd_valid,
    input  wire logic                 cmd_ready,
    output cmd_t                      cmd,
    output logic [KEY_LEN_W-1:0]      key_length
);

    logic [KEY_LEN_W-1:0] key_length_reg;
    logic [KEY_LEN_W-1:0] key_length_next;
    logic                 key_in_range;

    // Key length register: out-of-range writes leave it unchanged
    assign cfg_ready = 1'b1;

    always_comb begin
        key_length_next = key_length_reg;
        if (cfg_valid && (cfg_data != '0) && (cfg_data <= KEY_LEN_W'(SBOX_DEPTH))) begin
            key_length_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= KEY_LEN_W'(1);
        end else begin
            key_length_reg <= key_length_next;
        end
    end

    assign key_length = key_length_reg;

    // Classify the item; key writes past the store are taken and dropped
    assign key_in_range = ({1'b0, s_key_index} < 9'(KEY_DEPTH));

    always_comb begin
        cmd.data      = s_byte_value;
        cmd.key_index = s_key_index;
        if (!s_req_type) begin
            cmd.op = OP_KEY_WR;
        end else if (s_start_message) begin
            cmd.op = OP_DATA_START;
        end else begin
            cmd.op = OP_DATA;
        end
    end

    assign cmd_valid = s_valid && (s_req_type || key_in_range);
    assign s_ready   = cmd_ready;

endmodule

`default_nettype wire

// ----- sv/rc4_cmd_fifo.sv -----
// ============================================================================
// rc4_cmd_fifo
// Short command queue that decouples the front from the engine.
// ============================================================================
`default_nettype none

module rc4_cmd_fifo
    import rc4_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  cmd_t      push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != (FIFO_AW + 1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rc4_engine.sv -----
// ============================================================================
// rc4_engine
// Executes queued commands: key store writes, the key schedule and the
// keystream generator; the last two share one S-box RAM.
// ============================================================================
`default_nettype none

module rc4_engine
    import rc4_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  cmd_t                      cmd,
    input  wire logic [KEY_LEN_W-1:0] key_length,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_out_byte
);

    eng_state_t state_reg, state_next;

    // S-box RAM, valid bits model the identity reset
    logic [BYTE_W-1:0]     sbox_mem [SBOX_DEPTH];
    logic [SBOX_DEPTH-1:0] sbox_vld_reg;
    logic                  sbox_we;
    logic                  sbox_clr;
    logic [7:0]            sbox_wa;
    logic [BYTE_W-1:0]     sbox_wd;
    logic [7:0]            sbox_ra;
    logic [BYTE_W-1:0]     sbox_q_reg;
    logic                  sbox_q_vld_reg;
    logic [7:0]            sbox_ra_reg;
    logic [BYTE_W-1:0]     sbox_rd;

    // Key store RAM
    logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
    logic              key_we;
    logic [KEY_AW-1:0] key_wa;
    logic [KEY_AW-1:0] key_ra;
    logic [BYTE_W-1:0] key_q_reg;

    // Working registers
    logic [7:0]        i_reg, i_next;
    logic [7:0]        j_reg, j_next;
    logic [7:0]        n_reg, n_next;
    logic [7:0]        acc_reg, acc_next;
    logic [KEY_AW-1:0] kpos_reg, kpos_next;
    logic [7:0]        si_reg, si_next;
    logic [7:0]        sj_reg, sj_next;
    logic [7:0]        t_reg, t_next;
    logic              t_is_i_reg, t_is_i_next;
    logic              t_is_j_reg, t_is_j_next;
    logic [7:0]        byte_reg, byte_next;
    logic              out_vld_reg, out_vld_next;
    logic [7:0]        out_byte_reg, out_byte_next;

    logic [KEY_LEN_W-1:0] key_len_eff;
    logic [KEY_LEN_W-1:0] kpos_inc;
    logic [7:0]           ks_byte;
    logic                 out_free;

    assign key_len_eff = (key_length > KEY_LEN_W'(KEY_DEPTH)) ?
                         KEY_LEN_W'(KEY_DEPTH) : key_length;
    assign kpos_inc    = KEY_LEN_W'(kpos_reg) + KEY_LEN_W'(1);
    assign sbox_rd     = sbox_q_vld_reg ? sbox_q_reg : sbox_ra_reg;
    assign ks_byte     = t_is_j_reg ? si_reg : (t_is_i_reg ? sj_reg : sbox_rd);
    assign out_free    = !out_vld_reg || m_ready;
    assign cmd_ready   = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        n_next        = n_reg;
        acc_next      = acc_reg;
        kpos_next     = kpos_reg;
        si_next       = si_reg;
        sj_next       = sj_reg;
        t_next        = t_reg;
        t_is_i_next   = t_is_i_reg;
        t_is_j_next   = t_is_j_reg;
        byte_next     = byte_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        out_byte_next = out_byte_reg;
        sbox_we       = 1'b0;
        sbox_clr      = 1'b0;
        sbox_wa       = i_reg;
        sbox_wd       = sj_reg;
        sbox_ra       = n_reg;
        key_we        = 1'b0;
        key_wa        = cmd.key_index[KEY_AW-1:0];
        key_ra        = kpos_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    byte_next = cmd.data;
                    unique case (cmd.op)
                        OP_KEY_WR: begin
                            key_we = 1'b1;
                        end
                        OP_DATA: begin
                            i_next     = i_reg + 8'd1;
                            sbox_ra    = i_reg + 8'd1;
                            state_next = ST_PG_RD_J;
                        end
                        OP_DATA_START: begin
                            // identity permutation, restart key schedule
                            sbox_clr   = 1'b1;
                            n_next     = '0;
                            acc_next   = '0;
                            kpos_next  = '0;
                            state_next = ST_KS_RD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            // key schedule: one step per S-box entry, through ST_KS_RD, ST_KS_ACC, ST_KS_WR_N and ST_KS_WR_A
            ST_KS_RD: begin
                sbox_ra    = n_reg;
                key_ra     = kpos_reg;
                state_next = ST_KS_ACC;
            end
            ST_KS_ACC: begin
                acc_next   = acc_reg + sbox_rd + key_q_reg;
                si_next    = sbox_rd;
                sbox_ra    = acc_reg + sbox_rd + key_q_reg;
                state_next = ST_KS_WR_N;
            end
            ST_KS_WR_N: begin
                sbox_we    = 1'b1;
                sbox_wa    = n_reg;
                sbox_wd    = sbox_rd;
                state_next = ST_KS_WR_A;
            end
            ST_KS_WR_A: begin
                sbox_we = 1'b1;
                sbox_wa = acc_reg;
                sbox_wd = si_reg;
                n_next  = n_reg + 8'd1;
                if (kpos_inc >= key_len_eff) begin
                    kpos_next = '0;
                end else begin
                    kpos_next = kpos_inc[KEY_AW-1:0];
                end
                if (n_reg == 8'hFF) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_PG_RD_I;
                end else begin
                    state_next = ST_KS_RD;
                end
            end
            // keystream generator
            ST_PG_RD_I: begin
                i_next     = i_reg + 8'd1;
                sbox_ra    = i_reg + 8'd1;
                state_next = ST_PG_RD_J;
            end
            ST_PG_RD_J: begin
                si_next    = sbox_rd;
                j_next     = j_reg + sbox_rd;
                sbox_ra    = j_reg + sbox_rd;
                state_next = ST_PG_SWAP;
            end
            ST_PG_SWAP: begin
                sj_next     = sbox_rd;
                sbox_we     = 1'b1;
                sbox_wa     = i_reg;
                sbox_wd     = sbox_rd;
                t_next      = si_reg + sbox_rd;
                sbox_ra     = si_reg + sbox_rd;
                t_is_i_next = ((si_reg + sbox_rd) == i_reg);
                t_is_j_next = ((si_reg + sbox_rd) == j_reg);
                state_next  = ST_PG_OUT;
            end
            ST_PG_OUT: begin
                // second half of the swap; harmless to repeat while stalled
                sbox_we = 1'b1;
                sbox_wa = j_reg;
                sbox_wd = si_reg;
                sbox_ra = t_reg;
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_byte_next = byte_reg ^ ks_byte;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        acc_reg      <= acc_next;
        kpos_reg     <= kpos_next;
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        t_reg        <= t_next;
        t_is_i_reg   <= t_is_i_next;
        t_is_j_reg   <= t_is_j_next;
        byte_reg     <= byte_next;
        out_byte_reg <= out_byte_next;
    end

    // S-box valid bits: cleared at reset and at each key schedule
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sbox_vld_reg <= '0;
        end else if (sbox_clr) begin
            sbox_vld_reg <= '0;
        end else if (sbox_we) begin
            sbox_vld_reg[sbox_wa] <= 1'b1;
        end
    end

    // S-box RAM, registered read
    always_ff @(posedge aclk) begin
        if (sbox_we) begin
            sbox_mem[sbox_wa] <= sbox_wd;
        end
        sbox_q_reg     <= sbox_mem[sbox_ra];
        sbox_q_vld_reg <= sbox_vld_reg[sbox_ra];
        sbox_ra_reg    <= sbox_ra;
    end

    // Key store RAM, registered read
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_wa] <= cmd.data;
        end
        key_q_reg <= key_mem[key_ra];
    end

    assign m_valid    = out_vld_reg;
    assign m_out_byte = out_byte_reg;

endmodule

`default_nettype wire

// ----- sv/rc4_stream_cipher.sv -----
// ============================================================================
// rc4_stream_cipher
// RC4 stream cipher with a writable key store and a key length register.
// ============================================================================
// Usage:
//  - Input channel s_*: an item with s_req_type low writes s_byte_value into
//    the key store at s_key_index and gives no result. With s_req_type high
//    it is a data byte; the result on m_* is the byte XOR the next keystream
//    byte. Set s_start_message on the first byte of a message to rerun the
//    key schedule and clear both indices.
//  - cfg_*: writes key_length (1..256); other values are ignored. Write it
//    only while the block is idle.
//  - Items pass a four-entry command queue into the engine. A key write is
//    done in the idle state; a data byte reads S[i] and S[j], does the swap
//    writes and the keystream read, all bound by the single S-box RAM port
//    pair. A start byte first runs the key schedule over all 256 entries.
//  - Reset (aresetn low, synchronous) restores the identity S-box through
//    per-entry valid bits, zeroes the indices and sets key_length to 1.
//    The key store is not cleared. No clearing pass is needed.
//  - When the receiver stalls, the result waits in the output register and
//    the engine holds the next byte; the queue keeps taking items until full.
// ============================================================================
`default_nettype none

module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_req_type,
    input  wire logic [7:0]           s_byte_value,
    input  wire logic [7:0]           s_key_index,
    input  wire logic                 s_start_message,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [KEY_LEN_W-1:0] cfg_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_out_byte
);

    cmd_t                 front_cmd;
    logic                 front_valid;
    logic                 front_ready;
    cmd_t                 eng_cmd;
    logic                 eng_valid;
    logic                 eng_ready;
    logic [KEY_LEN_W-1:0] key_length;

    // Accept and classify
    rc4_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_byte_value    (s_byte_value),
        .s_key_index     (s_key_index),
        .s_start_message (s_start_message),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .cmd_valid       (front_valid),
        .cmd_ready       (front_ready),
        .cmd             (front_cmd),
        .key_length      (key_length)
    );

    // Command queue
    rc4_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (eng_valid),
        .pop_ready  (eng_ready),
        .pop_cmd    (eng_cmd)
    );

    // Cipher engine
    rc4_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (eng_valid),
        .cmd_ready  (eng_ready),
        .cmd        (eng_cmd),
        .key_length (key_length),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte)
    );

endmodule

`default_nettype wire

// ----- sv/rc4_checker.sv -----
// ============================================================================
// rc4_checker
// Port-level checks for the RC4 stream cipher, bound to the top level.
// ============================================================================
`default_nettype none

module rc4_checker
    import rc4_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 s_req_type,
    input wire logic                 cfg_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [7:0]           m_out_byte
);

    // Data items accepted but not yet delivered
    logic [7:0] pend_reg, pend_next;
    logic       data_in;
    logic       data_out;

    assign data_in  = s_valid && s_ready && s_req_type;
    assign data_out = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (data_in && !data_out) begin
            pend_next = pend_reg + 8'd1;
        end else if (!data_in && data_out) begin
            pend_next = pend_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // Result held until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte))
        else $error("result changed or dropped while stalled");

    // No result right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Every result belongs to an accepted data item
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 8'd0)
        else $error("result without a pending data item");

    // Configuration port never back-pressures
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_req_type (s_req_type),
    .cfg_ready  (cfg_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte)
);

`default_nettype wire
